FILE: rtl/jae_pkg.sv
// Shared types, codes and helpers of the JSON ASCII escape block.
package jae_pkg;

    // Kinds of output run that one input byte can cause
    localparam logic [1:0] KIND_CHAR = 2'd0;  // one plain character
    localparam logic [1:0] KIND_ESC2 = 2'd1;  // backslash and the character
    localparam logic [1:0] KIND_U    = 2'd2;  // one \uxxxx
    localparam logic [1:0] KIND_PAIR = 2'd3;  // surrogate pair \uxxxx\uxxxx

    localparam int RUN_IDX_W = 4;             // index of a character in a run (0..11)

    localparam logic [RUN_IDX_W-1:0] LAST_CHAR = 4'd0;
    localparam logic [RUN_IDX_W-1:0] LAST_ESC2 = 4'd1;
    localparam logic [RUN_IDX_W-1:0] LAST_U    = 4'd5;
    localparam logic [RUN_IDX_W-1:0] LAST_PAIR = 4'd11;
    localparam logic [RUN_IDX_W-1:0] HALF_LEN  = 4'd6;

    localparam logic [6:0] CH_QUOTE     = 7'h22;
    localparam logic [6:0] CH_BACKSLASH = 7'h5c;
    localparam logic [6:0] CH_U         = 7'h75;
    localparam logic [7:0] CH_DEL       = 8'h7f;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [5:0] HI_SURR_TOP = 6'b110110;  // 0xd800 >> 10
    localparam logic [5:0] LO_SURR_TOP = 6'b110111;  // 0xdc00 >> 10

    typedef struct packed {
        logic        valid;  // the byte causes at least one output character
        logic [1:0]  kind;
        logic [6:0]  ch;     // character for plain and two-character runs
        logic [15:0] val1;   // value of the first \u escape
        logic [15:0] val2;   // value of the second \u escape of a pair
    } run_desc_t;

    // Lowercase hex digit of a nibble
    function automatic logic [6:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10)
            return 7'h30 + {3'b000, nib};
        else
            return 7'h57 + {3'b000, nib};
    endfunction

endpackage

FILE: rtl/json_ascii_escape_utf8.sv
// Top level of the UTF-8 to ASCII JSON string escaper.
//
//  channel | dir | tdata bits (low first)          | tlast
//  --------+-----+---------------------------------+-------------------
//  s_axis  | in  | [7:0] in_byte                   | end_of_text
//  m_axis  | out | [6:0] out_byte, [7] zero        | last_of_run
//
//  Each input byte is decoded combinationally into a run descriptor that is
//  held in the emitter; the emitter then sends 1, 2, 6 or 12 characters,
//  one per transfer. Plain ASCII bytes therefore flow at one byte per cycle while
//  the output does not stall; after a byte that causes a longer run, the next
//  byte is taken only when the last character of that run is sent.
//  Bytes that produce nothing (lead bytes, dropped bytes) load nothing into the emitter.
//  The next byte is taken in the same cycle as the last character of the
//  current run. Reset clears the decoder and emitter; no sequence pending.
module json_ascii_escape_utf8
    import jae_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_byte, [7] zero
    output logic       m_tlast    // last_of_run
);

    run_desc_t  desc;
    logic       accept;
    logic       take_ok;
    logic [6:0] out_byte;

    // take a byte whenever the emitter is free or finishing its run
    assign s_tready = take_ok;
    assign accept   = s_tvalid && take_ok;
    assign m_tdata  = {1'b0, out_byte};

    jae_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (s_tdata),
        .end_of_text (s_tlast),
        .desc        (desc)
    );

    // load only bytes that produce output
    jae_emit u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept && desc.valid),
        .desc        (desc),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_byte    (out_byte),
        .last_of_run (m_tlast),
        .take_ok     (take_ok)
    );

endmodule

FILE: rtl/jae_decode.sv
// UTF-8 decoder state and byte classification into an output run descriptor.
module jae_decode
    import jae_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic [7:0] in_byte,
    input  logic      end_of_text,
    output run_desc_t desc
);

    logic [20:0] cp_reg, cp_next;
    logic [1:0]  need_reg, need_next;

    logic        cont;
    logic [20:0] acc;
    logic [20:0] offs;
    logic [1:0]  need_dec;

    always_comb
    begin
        cont      = (in_byte[7:6] == 2'b10);
        acc       = {cp_reg[14:0], in_byte[5:0]};
        need_dec  = need_reg - 2'd1;
        offs      = acc - 21'h010000;
        desc      = '0;
        cp_next   = '0;
        need_next = '0;

        if (need_reg != 2'd0 && cont)
        begin
            // continuation byte: fold in six bits
            need_next = need_dec;
            if (need_dec == 2'd0)
            begin
                desc.valid = 1'b1;
                if (acc[20:16] != 5'd0)
                begin
                    // high half can carry past 0xdbff for values above 0x10ffff
                    desc.kind = KIND_PAIR;
                    desc.val1 = {HI_SURR_TOP, 10'd0} + {5'd0, offs[20:10]};
                    desc.val2 = {LO_SURR_TOP, offs[9:0]};
                end
                else
                begin
                    desc.kind = KIND_U;
                    desc.val1 = acc[15:0];
                end
            end
            else
                cp_next = acc;
        end
        else
        begin
            // fresh byte; any partial sequence is dropped
            desc.ch = in_byte[6:0];
            if (in_byte[6:0] == CH_QUOTE && !in_byte[7] ||
                in_byte[6:0] == CH_BACKSLASH && !in_byte[7])
            begin
                desc.valid = 1'b1;
                desc.kind  = KIND_ESC2;
            end
            else if (in_byte < CH_SPACE || in_byte == CH_DEL)
            begin
                desc.valid = 1'b1;
                desc.kind  = KIND_U;
                desc.val1  = {8'h00, in_byte};
            end
            else if (!in_byte[7])
            begin
                desc.valid = 1'b1;
                desc.kind  = KIND_CHAR;
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                cp_next   = {16'd0, in_byte[4:0]};
                need_next = 2'd1;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                cp_next   = {17'd0, in_byte[3:0]};
                need_next = 2'd2;
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                cp_next   = {18'd0, in_byte[2:0]};
                need_next = 2'd3;
            end
        end

        // drop an unfinished sequence at end of text
        if (end_of_text)
        begin
            cp_next   = '0;
            need_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg   <= '0;
            need_reg <= '0;
        end
        else if (accept)
        begin
            cp_reg   <= cp_next;
            need_reg <= need_next;
        end
    end

endmodule

FILE: rtl/jae_emit.sv
// Run register and serializer that sends one escaped character per transfer.
module jae_emit
    import jae_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  run_desc_t desc,
    input  logic      m_tready,
    output logic      m_tvalid,
    output logic [6:0] out_byte,
    output logic      last_of_run,
    output logic      take_ok
);

    run_desc_t            desc_reg;
    logic                 valid_reg, valid_next;
    logic [RUN_IDX_W-1:0] idx_reg, idx_next;
    logic [RUN_IDX_W-1:0] last_idx;
    logic [RUN_IDX_W-1:0] pos;
    logic [15:0]          val;
    logic                 fire;

    always_comb
    begin
        case (desc_reg.kind)
            KIND_CHAR: last_idx = LAST_CHAR;
            KIND_ESC2: last_idx = LAST_ESC2;
            KIND_U:    last_idx = LAST_U;
            KIND_PAIR: last_idx = LAST_PAIR;
            default:   last_idx = LAST_CHAR;
        endcase

        // position inside the current \u escape
        if (idx_reg < HALF_LEN)
        begin
            pos = idx_reg;
            val = desc_reg.val1;
        end
        else
        begin
            pos = idx_reg - HALF_LEN;
            val = desc_reg.val2;
        end

        case (desc_reg.kind)
            KIND_CHAR: out_byte = desc_reg.ch;
            KIND_ESC2: out_byte = (idx_reg == '0) ? CH_BACKSLASH : desc_reg.ch;
            default:
            begin
                case (pos)
                    4'd0:    out_byte = CH_BACKSLASH;
                    4'd1:    out_byte = CH_U;
                    4'd2:    out_byte = hex_digit(val[15:12]);
                    4'd3:    out_byte = hex_digit(val[11:8]);
                    4'd4:    out_byte = hex_digit(val[7:4]);
                    default: out_byte = hex_digit(val[3:0]);
                endcase
            end
        endcase

        last_of_run = (idx_reg == last_idx);
        m_tvalid    = valid_reg;
        fire        = valid_reg && m_tready;
        take_ok     = !valid_reg || (fire && last_of_run);

        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (fire && last_of_run)
            valid_next = 1'b0;
        else if (fire)
            idx_next = idx_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            desc_reg <= desc;
    end

endmodule

FILE: rtl/jae_check.sv
// Port checker for the JSON ASCII escaper, bound to the top level.
module jae_check
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // hold a stalled output transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    // output is pure ASCII
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[7])
        else $error("output byte not ASCII");

    // an idle emitter always takes input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output idle");

    // a run continues without gaps until its last character
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("run broken before its last character");

endmodule

bind json_ascii_escape_utf8 jae_check u_check
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: tb/sv/json_ascii_escape_utf8_checker.sv
// Channel monitor, escape predictor and result comparator for json_ascii_escape_utf8.
module json_ascii_escape_utf8_checker
    import jae_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_text
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [6:0] out_byte, [7] zero
    input  logic       m_tlast,   // last_of_run
    output int         mismatches,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0]  HI_SURR_BASE = 16'hd800;
    localparam logic [15:0]  LO_SURR_BASE = 16'hdc00;
    localparam logic [20:0]  SUPP_BASE    = 21'h10000;
    localparam logic [127:0] HEX_LUT      = "0123456789abcdef";
    localparam int           MAX_REPORTS  = 40;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } esc_char_t;

    esc_char_t  esc_q[$];
    logic [6:0] run_chars[$];

    // Decoder state of the predictor
    logic [20:0] cp_acc   = '0;
    logic [1:0]  cont_left = '0;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Append one character to the run being predicted
    function automatic void add_run_char(input logic [6:0] c);
        run_chars = {run_chars, c};
    endfunction

    function automatic void put_u16(input logic [15:0] v);
        add_run_char(CH_BACKSLASH);
        add_run_char(CH_U);
        for (int i = 3; i >= 0; i--)
            add_run_char(HEX_LUT[(15 - int'(v[i*4 +: 4]))*8 +: 7]);
    endfunction

    function automatic void put_code_point(input logic [20:0] cp);
        logic [20:0] off;
        if (cp >= SUPP_BASE) begin
            off = cp - SUPP_BASE;
            put_u16(HI_SURR_BASE + {5'd0, off[20:10]});
            put_u16(LO_SURR_BASE + {6'd0, off[9:0]});
        end
        else begin
            put_u16(cp[15:0]);
        end
    endfunction

    function automatic void decode_fresh(input logic [7:0] b);
        if (b == {1'b0, CH_QUOTE} || b == {1'b0, CH_BACKSLASH}) begin
            add_run_char(CH_BACKSLASH);
            add_run_char(b[6:0]);
        end
        else if (b < CH_SPACE || b == CH_DEL) begin
            put_u16({8'h00, b});
        end
        else if (!b[7]) begin
            add_run_char(b[6:0]);
        end
        else if (b[7:5] == 3'b110) begin
            cp_acc    = {16'd0, b[4:0]};
            cont_left = 2'd1;
        end
        else if (b[7:4] == 4'b1110) begin
            cp_acc    = {17'd0, b[3:0]};
            cont_left = 2'd2;
        end
        else if (b[7:3] == 5'b11110) begin
            cp_acc    = {18'd0, b[2:0]};
            cont_left = 2'd3;
        end
        // stray continuation and 0xf8..0xff lead bytes: drop
    endfunction

    function automatic void predict_escape(input logic [7:0] b, input logic eot);
        esc_char_t e;
        run_chars.delete();
        if (cont_left != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                cp_acc    = {cp_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    put_code_point(cp_acc);
                    cp_acc = '0;
                end
            end
            else begin
                // broken sequence: forget it, treat the byte as new
                cp_acc    = '0;
                cont_left = '0;
                decode_fresh(b);
            end
        end
        else begin
            decode_fresh(b);
        end
        // unfinished sequence at end of text is discarded
        if (eot && cont_left != 2'd0) begin
            cp_acc    = '0;
            cont_left = '0;
        end
        foreach (run_chars[i]) begin
            e.ch   = run_chars[i];
            e.last = (i == run_chars.size() - 1);
            esc_q  = {esc_q, e};
        end
    endfunction

    always @(posedge clk) begin : watch
        esc_char_t want;
        if (rst_n) begin
            if (s_tvalid && s_tready)
                predict_escape(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (esc_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected output 0x%02h last=%0b",
                                              m_tdata, m_tlast));
                end
                else begin
                    want = esc_q.pop_front();
                    if (m_tdata[6:0] !== want.ch)
                        report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h",
                                                  m_tdata[6:0], want.ch));
                    if (m_tdata[7] !== 1'b0)
                        report_mismatch("tdata pad bit not zero");
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last_of_run %0b, want %0b (char 0x%02h)",
                                                  m_tlast, want.last, want.ch));
                end
            end
            outstanding = esc_q.size();
        end
    end

endmodule

FILE: tb/sv/json_ascii_escape_utf8_tb.sv
// Stimulus, clock, reset and verdict for the json_ascii_escape_utf8 testbench.
module json_ascii_escape_utf8_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous bound: ~200 bytes, each up to 12 chars, each char stalled for long
    localparam int CYCLE_LIMIT  = 300000;
    // Cycles to let pass after the last expected char; a byte that yields
    // nothing still needs to be taken by the design
    localparam int DRAIN_SETTLE = 16;
    localparam int PHASE_ITEMS  = 40;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] in_byte
    logic       s_tlast;    // end_of_text
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [6:0] out_byte, [7] zero
    logic       m_tlast;    // last_of_run

    int mismatches;
    int outstanding;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int bytes_sent   = 0;
    int cycle_count  = 0;

    json_ascii_escape_utf8 DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    json_ascii_escape_utf8_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a stuck handshake or a missing result ends here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("json_ascii_escape_utf8_tb: FAIL");
            $finish;
        end
    end

    // Receiver: drop tready at random, rate set by the current phase
    always @(negedge clk) begin
        m_tready <= rst_n && ($urandom_range(99) >= rcv_idle_pct);
    end

    // Offer one byte, optionally after an idle gap, and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        if ($urandom_range(99) < snd_idle_pct) begin
            gap = $urandom_range(3, 1);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    // Stop sending and wait until every predicted char has come out
    task automatic hold_until_drained;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_SETTLE) @(negedge clk);
    endtask

    // Encode a value as a UTF-8 sequence of nb bytes (overlong allowed);
    // send only the first n_send bytes and mark end of text on the last sent
    task automatic send_utf8(input logic [20:0] cp, input int nb, input int n_send,
                             input logic eot);
        logic [7:0] seq [4];
        case (nb)
            1: seq[0] = {1'b0, cp[6:0]};
            2: seq[0] = {3'b110, cp[10:6]};
            3: seq[0] = {4'b1110, cp[15:12]};
            default: seq[0] = {5'b11110, cp[20:18]};
        endcase
        seq[1] = {2'b10, (nb == 4) ? cp[17:12] : (nb == 3) ? cp[11:6] : cp[5:0]};
        seq[2] = {2'b10, (nb == 4) ? cp[11:6] : cp[5:0]};
        seq[3] = {2'b10, cp[5:0]};
        for (int i = 0; i < n_send; i++)
            send_byte(seq[i], eot && (i == n_send - 1));
    endtask

    task automatic random_phase(input int target);
        int          pick;
        int          nb;
        logic [20:0] cp;
        logic [7:0]  special [6];
        special = '{8'h22, 8'h5c, 8'h00, 8'h1f, 8'h7f, 8'h0a};
        target = bytes_sent + target;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            nb   = $urandom_range(4, 1);
            cp   = 21'($urandom);
            if (nb == 1) cp = cp & 21'h7f;
            else if (nb == 2) cp = cp & 21'h7ff;
            else if (nb == 3) cp = cp & 21'hffff;
            if (pick < 45) begin
                // well-formed sequence with random content
                send_utf8(cp, nb, nb, $urandom_range(9) == 0);
            end
            else if (pick < 60) begin
                send_byte(special[$urandom_range(5)], $urandom_range(9) == 0);
            end
            else if (pick < 75) begin
                // broken: cut a multi-byte sequence short, follow with any byte
                nb = $urandom_range(4, 2);
                send_utf8(cp, nb, $urandom_range(nb - 1, 1), 1'b0);
                send_byte(8'($urandom), $urandom_range(9) == 0);
            end
            else if (pick < 85) begin
                // truncated at end of text
                nb = $urandom_range(4, 2);
                send_utf8(cp, nb, $urandom_range(nb - 1, 1), 1'b1);
            end
            else begin
                send_byte(8'($urandom), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Phase one: sender idles rarely, receiver stalls often
        snd_idle_pct = 12;
        rcv_idle_pct = 64;

        // Directed: ASCII boundary values and escapes
        send_byte(8'h00, 1'b0);
        send_byte(8'h1f, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h5c, 1'b0);
        send_byte(8'h7e, 1'b0);
        send_byte(8'h7f, 1'b0);
        // stray continuation byte and invalid lead byte
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b0);
        // two, three and four byte sequences, and the largest 4-byte value
        send_utf8(21'h0000a9, 2, 2, 1'b0);
        send_utf8(21'h0020ac, 3, 3, 1'b0);
        send_utf8(21'h01f600, 4, 4, 1'b0);
        send_utf8(21'h1fffff, 4, 4, 1'b0);
        // broken sequence: letter interrupts a three-byte sequence
        send_utf8(21'h0020ac, 3, 2, 1'b0);
        send_byte(8'h41, 1'b0);
        // overlong NUL and an encoded surrogate pass through as values
        send_utf8(21'h000000, 2, 2, 1'b0);
        send_utf8(21'h00d800, 3, 3, 1'b0);
        // truncated at end of text, then fresh text
        send_utf8(21'h0020ac, 3, 2, 1'b1);
        send_byte(8'h41, 1'b1);

        random_phase(PHASE_ITEMS);
        hold_until_drained();

        // Phase two: sender idles often, receiver stalls rarely
        snd_idle_pct = 64;
        rcv_idle_pct = 12;
        random_phase(PHASE_ITEMS);
        hold_until_drained();

        // Phase three: full rate on both sides
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        random_phase(PHASE_ITEMS);
        hold_until_drained();

        if (mismatches == 0 && outstanding == 0)
            $display("json_ascii_escape_utf8_tb: PASS");
        else
            $display("json_ascii_escape_utf8_tb: FAIL");
        $finish;
    end

endmodule
